FILE: hw/rtl/dkpq_pkg.sv
// ----------------------------------------------------------------------------
// Date-keyed priority queue package
// Shared constants, codes and types of the date-keyed stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dkpq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [7:0] NAME_LEN_MIN = 8'd1;
   localparam logic [7:0] NAME_LEN_MAX = 8'd11;
   localparam logic [3:0] MONTH_MIN    = 4'd1;
   localparam logic [3:0] MONTH_MAX    = 4'd12;
   localparam logic [4:0] DAY_MIN      = 5'd1;
   localparam logic [4:0] DAY_MAX      = 5'd31;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_NAME = 3'd1,
      ST_BAD_DATE = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [3:0]  month;
      logic [4:0]  day;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_type;

   // month is the major key, day the minor key
   function automatic logic [8:0] date_key(input entry_type e);
      return {e.month, e.day};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dkpq_if.sv
// ----------------------------------------------------------------------------
// Date-keyed priority queue channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface dkpq_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  name_length;
   logic [3:0]  due_month;
   logic [4:0]  due_day;
   logic [15:0] entry_tag;

   modport source (output valid, cmd, name_length, due_month, due_day, entry_tag,
                   input ready);
   modport sink   (input valid, cmd, name_length, due_month, due_day, entry_tag,
                   output ready);
endinterface

interface dkpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] out_tag;
   logic [3:0]  out_month;
   logic [4:0]  out_day;

   modport source (output valid, status, out_tag, out_month, out_day, input ready);
   modport sink   (input valid, status, out_tag, out_month, out_day, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/date_keyed_stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Date-keyed stable priority queue
// Holds up to DEPTH entries (tag, month, day) sorted by due date, earliest
// first; equal dates leave in arrival order. An enqueue is checked for name
// length, then date, then room, and the first failing check is reported. A
// dequeue returns and removes the front entry or reports empty. Each request
// produces exactly one response. A request is captured, then committed:
// every cell compares its date with the new one; the entries behind the
// insert slot, or all on a dequeue, shift. The next request is accepted after
// that; a stalled response holds the commit until its register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module date_keyed_stable_priority_queue_top
   import dkpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic      clock,
   input  logic      reset,
   dkpq_req_if.sink  req,
   dkpq_rsp_if.source rsp
);

   ctrl_type ctrl;

   dkpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctrl      (ctrl)
   );

   dkpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_cmd         (req.cmd),
      .req_name_length (req.name_length),
      .req_due_month   (req.due_month),
      .req_due_day     (req.due_day),
      .req_entry_tag   (req.entry_tag),
      .rsp_status      (rsp.status),
      .rsp_out_tag     (rsp.out_tag),
      .rsp_out_month   (rsp.out_month),
      .rsp_out_day     (rsp.out_day)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/dkpq_ctrl.sv
// ----------------------------------------------------------------------------
// Date-keyed priority queue controller
// Sequences capture and commit of one transaction and owns the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dkpq_ctrl
   import dkpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         S_EXEC: begin
            ctrl.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dkpq_datapath.sv
// ----------------------------------------------------------------------------
// Date-keyed priority queue datapath
// Request register, sorted cell row with parallel compare and shift, entry
// count and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module dkpq_datapath
   import dkpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic        req_cmd,
   input  logic [7:0]  req_name_length,
   input  logic [3:0]  req_due_month,
   input  logic [4:0]  req_due_day,
   input  logic [15:0] req_entry_tag,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_tag,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type            cmd_ff;
   logic [7:0]         len_ff;
   entry_type          new_entry_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   entry_type          cells_ff [DEPTH];
   status_type         status_ff, status_in;
   entry_type          out_ff, out_in;

   logic               name_bad, date_bad, full, empty;
   logic               do_insert, do_remove;
   logic [DEPTH-1:0]   take;
   logic [DEPTH-1:0]   take_prev;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff             <= cmd_type'(req_cmd);
         len_ff             <= req_name_length;
         new_entry_ff.tag   <= req_entry_tag;
         new_entry_ff.month <= req_due_month;
         new_entry_ff.day   <= req_due_day;
      end
   end

   assign name_bad = (len_ff < NAME_LEN_MIN) || (len_ff > NAME_LEN_MAX);
   assign date_bad = (new_entry_ff.month < MONTH_MIN) || (new_entry_ff.month > MONTH_MAX) ||
                     (new_entry_ff.day < DAY_MIN) || (new_entry_ff.day > DAY_MAX);
   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);

   always_comb begin
      status_in = ST_OK;
      if (cmd_ff == CMD_ENQUEUE) begin
         if (name_bad)      status_in = ST_BAD_NAME;
         else if (date_bad) status_in = ST_BAD_DATE;
         else if (full)     status_in = ST_FULL;
      end else begin
         if (empty) status_in = ST_EMPTY;
      end
   end

   assign do_insert = ctrl.commit && (cmd_ff == CMD_ENQUEUE) && (status_in == ST_OK);
   assign do_remove = ctrl.commit && (cmd_ff == CMD_DEQUEUE) && !empty;

   // take marks the insert slot and every stored entry behind it
   assign take_prev = {take[DEPTH-2:0], 1'b0};

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         entry_type below, above, cell_in;

         assign take[g] = (count_ff > CNT_W'(g)) ?
                          (date_key(cells_ff[g]) > date_key(new_entry_ff)) :
                          (count_ff == CNT_W'(g));

         if (g == 0) begin : g_first
            assign below = new_entry_ff;
         end else begin : g_rest
            assign below = cells_ff[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign above = cells_ff[g];
         end else begin : g_inner
            assign above = cells_ff[g+1];
         end

         always_comb begin
            cell_in = cells_ff[g];
            if (do_insert && take[g]) begin
               cell_in = take_prev[g] ? below : new_entry_ff;
            end else if (do_remove) begin
               cell_in = above;
            end
         end

         always_ff @(posedge clock) begin
            if (do_insert || do_remove) cells_ff[g] <= cell_in;
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (do_insert)      count_in = count_ff + 1'b1;
      else if (do_remove) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_in = do_remove ? cells_ff[0] : '0;

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         status_ff <= status_in;
         out_ff    <= out_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_out_tag   = out_ff.tag;
   assign rsp_out_month = out_ff.month;
   assign rsp_out_day   = out_ff.day;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the count");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      do_remove |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not shrink the count");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> date_key(cells_ff[0]) <= date_key(cells_ff[1]))
      else $error("front entries out of order");

endmodule

`default_nettype wire

FILE: test/dkpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-keyed priority queue checker
// Watches the request and response channels. Keeps its own sorted copy of the
// queue, works out the response to every accepted request and compares each
// accepted response, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module dkpq_checker
   import dkpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_name_length,
   input  logic [3:0]  req_due_month,
   input  logic [4:0]  req_due_day,
   input  logic [15:0] req_entry_tag,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_out_tag,
   input  logic [3:0]  rsp_out_month,
   input  logic [4:0]  rsp_out_day,
   output int          mismatch_count,
   output int          pending_responses,
   output int          responses_checked,
   output logic [4:0]  status_seen
);

   typedef struct {
      status_type  status;
      logic [15:0] tag;
      logic [3:0]  month;
      logic [4:0]  day;
   } response_type;

   entry_type    queued_entries[$];
   response_type expected_responses[$];

   function automatic response_type predict_response(input logic        cmd,
                                                     input logic [7:0]  name_len,
                                                     input logic [3:0]  month,
                                                     input logic [4:0]  day,
                                                     input logic [15:0] tag);
      response_type res;
      entry_type    e;
      int           pos;
      res.status = ST_OK;
      res.tag    = '0;
      res.month  = '0;
      res.day    = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (name_len < NAME_LEN_MIN || name_len > NAME_LEN_MAX) begin
            res.status = ST_BAD_NAME;
         end else if (month < MONTH_MIN || month > MONTH_MAX || day < DAY_MIN) begin
            res.status = ST_BAD_DATE;
         end else if (queued_entries.size() >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            e.tag   = tag;
            e.month = month;
            e.day   = day;
            // new entry goes behind every entry of the same or an earlier date
            pos = 0;
            while (pos < queued_entries.size() &&
                   {queued_entries[pos].month, queued_entries[pos].day} <= {month, day})
               pos++;
            queued_entries.insert(pos, e);
         end
      end else begin
         if (queued_entries.size() == 0) begin
            res.status = ST_EMPTY;
         end else begin
            e         = queued_entries.pop_front();
            res.tag   = e.tag;
            res.month = e.month;
            res.day   = e.day;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         queued_entries.delete();
         expected_responses.delete();
         mismatch_count    = 0;
         pending_responses = 0;
         responses_checked = 0;
         status_seen       = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no outstanding request: status %0d tag %h",
                      rsp_status, rsp_out_tag);
               mismatch_count++;
            end else begin
               want = expected_responses.pop_front();
               responses_checked++;
               if (rsp_status < 3'd5)
                  status_seen[rsp_status] = 1'b1;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_out_tag !== want.tag) begin
                  $error("out_tag: expected %h, actual %h", want.tag, rsp_out_tag);
                  mismatch_count++;
               end
               if (rsp_out_month !== want.month) begin
                  $error("out_month: expected %0d, actual %0d", want.month, rsp_out_month);
                  mismatch_count++;
               end
               if (rsp_out_day !== want.day) begin
                  $error("out_day: expected %0d, actual %0d", want.day, rsp_out_day);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_responses.push_back(predict_response(req_cmd, req_name_length,
                                                          req_due_month, req_due_day,
                                                          req_entry_tag));
         pending_responses = expected_responses.size();
      end
   end

endmodule

`default_nettype wire

FILE: test/tb_date_keyed_stable_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-keyed stable priority queue testbench
// Drives a directed set of enqueues and dequeues (bad names, bad dates, a
// full and an empty queue, equal dates) followed by random traffic whose
// enqueue share drifts so the queue swings between empty and full. Both
// channels idle in random bursts; the response side holds off once for a
// long stretch. The checker predicts and compares every transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_date_keyed_stable_priority_queue_top;
   import dkpq_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1100;
   localparam int CALM_TAIL    = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock;
   logic reset;
   logic quiet;
   logic hold_go;
   logic hold_done;
   int   cycle_count = 0;
   int   sent_count;
   int   mismatch_count;
   int   pending_responses;
   int   responses_checked;
   logic [4:0] status_seen;

   dkpq_req_if req();
   dkpq_rsp_if rsp();

   date_keyed_stable_priority_queue_top #(.DEPTH(DEPTH)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   dkpq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req.valid),
      .req_ready         (req.ready),
      .req_cmd           (req.cmd),
      .req_name_length   (req.name_length),
      .req_due_month     (req.due_month),
      .req_due_day       (req.due_day),
      .req_entry_tag     (req.entry_tag),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_status        (rsp.status),
      .rsp_out_tag       (rsp.out_tag),
      .rsp_out_month     (rsp.out_month),
      .rsp_out_day       (rsp.out_day),
      .mismatch_count    (mismatch_count),
      .pending_responses (pending_responses),
      .responses_checked (responses_checked),
      .status_seen       (status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_responses);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off
   initial begin
      int burst;
      rsp.ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp.ready <= 1'b0;
         end else if (hold_go && !hold_done) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            burst = $urandom_range(0, 12);
            repeat (burst) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic offer_request(input logic        cmd,
                                input logic [7:0]  name_len,
                                input logic [3:0]  month,
                                input logic [4:0]  day,
                                input logic [15:0] tag);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.cmd         <= cmd;
      req.name_length <= name_len;
      req.due_month   <= month;
      req.due_day     <= day;
      req.entry_tag   <= tag;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req.valid <= 1'b0;
      while (pending_responses != 0) @(negedge clock);
   endtask

   task automatic offer_random_request(input int enqueue_pct);
      int          pick;
      logic [7:0]  name_len;
      logic [3:0]  month;
      logic [4:0]  day;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         // noise: anything the fields allow, mostly rejected
         name_len = 8'($urandom_range(0, 255));
         month    = 4'($urandom_range(0, 15));
         day      = 5'($urandom_range(0, 31));
         if ($urandom_range(0, 1) == 0) begin
            name_len = 8'($urandom_range(1, 11));
            if ($urandom_range(0, 1) == 0)
               month = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
            else
               day = 5'd0;
         end
         offer_request(CMD_ENQUEUE, name_len, month, day, 16'($urandom));
      end else if ($urandom_range(0, 99) < enqueue_pct) begin
         name_len = 8'($urandom_range(1, 11));
         if ($urandom_range(0, 9) < 4) begin
            // narrow date range: many equal dates
            month = 4'($urandom_range(1, 2));
            day   = 5'($urandom_range(1, 3));
         end else begin
            month = 4'($urandom_range(1, 12));
            day   = 5'($urandom_range(1, 31));
         end
         offer_request(CMD_ENQUEUE, name_len, month, day, 16'($urandom));
      end else begin
         offer_request(CMD_DEQUEUE, 8'($urandom), 4'($urandom), 5'($urandom),
                       16'($urandom));
      end
   endtask

   initial begin
      int   i;
      int   enqueue_pct;
      logic [3:0] month;
      logic [4:0] day;
      logic [15:0] tag;
      sent_count      = 0;
      quiet           = 1'b0;
      hold_go         = 1'b0;
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.cmd         = CMD_ENQUEUE;
      req.name_length = '0;
      req.due_month   = '0;
      req.due_day     = '0;
      req.entry_tag   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty, bad names (checked before the date), bad dates
      offer_request(CMD_DEQUEUE, 8'd0, 4'd0, 5'd0, 16'h0000);
      offer_request(CMD_ENQUEUE, 8'd0, 4'd5, 5'd5, 16'h0101);
      offer_request(CMD_ENQUEUE, 8'd12, 4'd0, 5'd0, 16'h0102);
      offer_request(CMD_ENQUEUE, 8'd255, 4'd3, 5'd3, 16'h0103);
      offer_request(CMD_ENQUEUE, 8'd1, 4'd0, 5'd7, 16'h0104);
      offer_request(CMD_ENQUEUE, 8'd11, 4'd13, 5'd7, 16'h0105);
      offer_request(CMD_ENQUEUE, 8'd5, 4'd15, 5'd31, 16'h0106);
      offer_request(CMD_ENQUEUE, 8'd5, 4'd6, 5'd0, 16'h0107);
      // fill the store, extremes of date and tag, repeated dates
      for (i = 0; i < DEPTH; i++) begin
         case (i)
            0: begin
               month = MONTH_MAX; day = DAY_MAX; tag = 16'hFFFF;
            end
            1: begin
               month = MONTH_MIN; day = DAY_MIN; tag = 16'h0000;
            end
            default: begin
               month = 4'(1 + (i % 3) * 5);
               day   = (i % 2) ? 5'd15 : 5'd1;
               tag   = 16'(16'h1000 + i);
            end
         endcase
         offer_request(CMD_ENQUEUE, 8'($urandom_range(1, 11)), month, day, tag);
      end
      offer_request(CMD_ENQUEUE, 8'd3, 4'd2, 5'd2, 16'h0201);
      offer_request(CMD_ENQUEUE, 8'd0, 4'd2, 5'd2, 16'h0202);
      offer_request(CMD_DEQUEUE, 8'd0, 4'd0, 5'd0, 16'h0000);
      wait_until_drained();

      // random traffic, enqueue share drifting every hundred transactions
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         case ((i / 100) % 5)
            0: enqueue_pct = 70;
            1: enqueue_pct = 30;
            2: enqueue_pct = 55;
            3: enqueue_pct = 85;
            default: enqueue_pct = 15;
         endcase
         if (i == 300)
            hold_go = 1'b1;
         if (i == 700)
            wait_until_drained();
         quiet = (i >= RANDOM_ITEMS - CALM_TAIL) || (i >= 500 && i < 560);
         offer_random_request(enqueue_pct);
      end
      req.valid <= 1'b0;

      while (pending_responses != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses; status codes seen (bit per code): %b",
               sent_count, responses_checked, status_seen);
      $display("Queue driven through full and empty, with a long response hold-off.");
      if (mismatch_count == 0 && pending_responses == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
